// File: rtl/core/efd_pkg.sv
// shared constants and types for the escaped frame decoder
package efd_pkg;

  localparam int unsigned MaxFrameDef = 21;

  localparam logic [7:0] SymStart = 8'hFA;
  localparam logic [7:0] SymEnd   = 8'hFD;
  localparam logic [7:0] SymEsc   = 8'hFE;

  localparam int unsigned LenW = 5;

  typedef enum logic [1:0] {
    S_COLLECT = 2'b01,
    S_DRAIN   = 2'b10
  } efd_state_t;

endpackage

// File: rtl/core/escaped_frame_decoder_top.sv
// byte-stuffed frame decoder with xor checksum, top level
// first beat: drain state, store read, output register; no store read if checksum only
// throughput: one input byte per cycle while a frame is collected
// payload drain: each store read waits until the previous one has loaded the output register
// input is held off during the drain and while the final store read is pending
// reset: synchronous active-low rst_n clears control state; byte store content stays undefined
module escaped_frame_decoder_top #(
  parameter int unsigned MaxFrame = efd_pkg::MaxFrameDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_rx_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_payload_byte,
  output logic                     out_last,
  output logic [efd_pkg::LenW-1:0] out_payload_len,
  output logic                     out_empty_frame
);
  import efd_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxFrame);
  localparam int unsigned CntW  = $clog2(MaxFrame + 1);

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  efd_ctrl #(
    .MaxFrame (MaxFrame),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last),
    .out_payload_len  (out_payload_len),
    .out_empty_frame  (out_empty_frame),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data)
  );

  efd_store #(
    .Depth (MaxFrame),
    .AddrW (AddrW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/core/efd_store.sv
// frame byte store, one write port and one registered read port
module efd_store #(
  parameter int unsigned Depth = 21,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem_r [Depth];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/efd_ctrl.sv
// frame parser, checksum and payload drain sequencer around the byte store
module efd_ctrl #(
  parameter int unsigned MaxFrame = efd_pkg::MaxFrameDef,
  parameter int unsigned AddrW    = 5,
  parameter int unsigned CntW     = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_rx_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_payload_byte,
  output logic                     out_last,
  output logic [efd_pkg::LenW-1:0] out_payload_len,
  output logic                     out_empty_frame,
  output logic                     wr_en,
  output logic [AddrW-1:0]         wr_addr,
  output logic [7:0]               wr_data,
  output logic                     rd_en,
  output logic [AddrW-1:0]         rd_addr,
  input  logic [7:0]               rd_data
);
  import efd_pkg::*;

  localparam int unsigned ExtW = (CntW > LenW) ? CntW : LenW;

  efd_state_t      state_r, state_nxt;
  logic            in_frame_r, in_frame_nxt;
  logic            esc_r, esc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      xor_r, xor_nxt;
  logic [CntW-1:0] plen_r, plen_nxt;
  logic            empty_r, empty_nxt;
  logic [AddrW-1:0] idx_r, idx_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic            pend_last_r, pend_last_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r, out_byte_nxt;
  logic            out_last_r, out_last_nxt;
  logic [LenW-1:0] out_len_r, out_len_nxt;
  logic            out_empty_r, out_empty_nxt;

  logic            accept;
  logic            is_start, is_end, is_esc;
  logic            do_collect, do_finish;
  logic            slot;
  logic            load_empty;
  logic            drain_last;
  logic [ExtW-1:0] plen_ext;

  assign is_start   = (in_rx_byte == SymStart);
  assign is_end     = (in_rx_byte == SymEnd);
  assign is_esc     = (in_rx_byte == SymEsc);
  assign in_ready   = (state_r == S_COLLECT) && !rd_pend_r;
  assign accept     = in_valid && in_ready;
  assign slot       = !rd_pend_r && (!out_valid_r || out_ready);
  assign drain_last = (CntW'(idx_r) == (plen_r - CntW'(1)));
  assign plen_ext   = ExtW'(plen_r);

  always_comb begin
    state_nxt     = state_r;
    in_frame_nxt  = in_frame_r;
    esc_nxt       = esc_r;
    cnt_nxt       = cnt_r;
    xor_nxt       = xor_r;
    plen_nxt      = plen_r;
    empty_nxt     = empty_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = 1'b0;
    pend_last_nxt = pend_last_r;
    do_collect    = 1'b0;
    do_finish     = 1'b0;
    load_empty    = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AddrW-1:0];
    wr_data       = in_rx_byte;
    rd_en         = 1'b0;
    rd_addr       = idx_r;

    if (accept) begin
      if (!in_frame_r) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (is_start) begin
          in_frame_nxt = 1'b1;
          cnt_nxt      = '0;
          xor_nxt      = '0;
        end else if (is_esc) begin
          esc_nxt = 1'b1;
        end
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        if (is_start || is_end || is_esc) begin
          do_collect = 1'b1;
        end else begin
          in_frame_nxt = 1'b0;
        end
      end else if (is_start) begin
        cnt_nxt = '0;
        xor_nxt = '0;
      end else if (is_end) begin
        do_finish = 1'b1;
      end else if (is_esc) begin
        esc_nxt = 1'b1;
      end else begin
        do_collect = 1'b1;
      end
    end

    if (do_collect) begin
      if (cnt_r >= CntW'(MaxFrame)) begin
        in_frame_nxt = 1'b0;
      end else begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CntW'(1);
        xor_nxt = xor_r ^ in_rx_byte;
      end
    end

    if (do_finish) begin
      in_frame_nxt = 1'b0;
      if ((cnt_r != '0) && (xor_r == '0)) begin
        state_nxt = S_DRAIN;
        idx_nxt   = '0;
        plen_nxt  = cnt_r - CntW'(1);
        empty_nxt = (cnt_r == CntW'(1));
      end
    end

    unique case (state_r)
      S_COLLECT: begin
      end
      S_DRAIN: begin
        if (slot) begin
          if (empty_r) begin
            load_empty = 1'b1;
            state_nxt  = S_COLLECT;
          end else begin
            rd_en         = 1'b1;
            rd_pend_nxt   = 1'b1;
            pend_last_nxt = drain_last;
            idx_nxt       = idx_r + AddrW'(1);
            if (drain_last) begin
              state_nxt = S_COLLECT;
            end
          end
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  // output register, loaded in the cycle after a store read, or directly with an empty-frame beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_len_nxt   = out_len_r;
    out_empty_nxt = out_empty_r;
    priority if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rd_data;
      out_last_nxt  = pend_last_r;
      out_len_nxt   = plen_ext[LenW-1:0];
      out_empty_nxt = 1'b0;
    end else if (load_empty) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = '0;
      out_last_nxt  = 1'b1;
      out_len_nxt   = '0;
      out_empty_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      xor_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
      xor_r       <= xor_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plen_r      <= plen_nxt;
    empty_r     <= empty_nxt;
    idx_r       <= idx_nxt;
    pend_last_r <= pend_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_len_r   <= out_len_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_last         = out_last_r;
  assign out_payload_len  = out_len_r;
  assign out_empty_frame  = out_empty_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxFrame))
    else $error("byte count beyond frame limit");

  a_read_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == S_DRAIN))
    else $error("store read outside drain");

  a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) && !empty_r |-> (CntW'(idx_r) < plen_r))
    else $error("drain index past payload length");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(!out_valid_r || out_ready))
    else $error("store read issued with output register blocked");
`endif

endmodule

// File: tb/testbench.sv
// self-checking testbench for escaped_frame_decoder_top with random handshake gaps
`timescale 1ns / 100ps

module testbench;
  import efd_pkg::*;

  localparam int RxItems = 420;
  localparam int StuckLimit = 2000;
  localparam int DrainPad = 24;

  typedef enum int {FLAW_NONE, FLAW_CHECKSUM, FLAW_ESCAPE} flaw_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic last;
    logic [LenW-1:0] plen;
    logic empty;
  } payload_beat_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_payload_byte;
  logic out_last;
  logic [LenW-1:0] out_payload_len;
  logic out_empty_frame;

  logic [7:0] rx_stream[$];
  payload_beat_t payload_due[$];

  // decoder state mirror
  logic frame_open = 1'b0;
  logic esc_armed = 1'b0;
  int held = 0;
  logic [7:0] parity = 8'h00;
  logic [7:0] frame_bytes[MaxFrameDef];

  int bytes_taken = 0;
  int rx_total = 0;
  int beats_checked = 0;
  int frames_done = 0;
  int errors = 0;
  int gap_in = 0;
  int quiet_in = 0;
  int hold_out = 0;
  int quiet_out = 0;
  int stuck_cycles = 0;

  escaped_frame_decoder_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload_byte(out_payload_byte),
    .out_last(out_last),
    .out_payload_len(out_payload_len),
    .out_empty_frame(out_empty_frame)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      quiet = $urandom_range(80, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b inside {SymStart, SymEnd, SymEsc});
    return b;
  endfunction

  function automatic logic [7:0] data_byte();
    case ($urandom_range(19))
      0: return SymStart;
      1: return SymEnd;
      2: return SymEsc;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_frame(input logic [7:0] body[$], input flaw_t flaw);
    logic [7:0] sum;
    int cut;
    sum = 8'h00;
    foreach (body[i]) sum ^= body[i];
    if (flaw == FLAW_CHECKSUM) sum ^= 8'($urandom_range(255, 1));
    body.push_back(sum);
    cut = (flaw == FLAW_ESCAPE) ? int'($urandom_range(body.size() - 1)) : -1;
    rx_stream.push_back(SymStart);
    foreach (body[i]) begin
      if (i == cut) begin
        rx_stream.push_back(SymEsc);
        rx_stream.push_back(plain_byte());
      end
      if (body[i] inside {SymStart, SymEnd, SymEsc}) rx_stream.push_back(SymEsc);
      rx_stream.push_back(body[i]);
    end
    rx_stream.push_back(SymEnd);
  endtask

  task automatic store_byte(input logic [7:0] b);
    if (held >= MaxFrameDef) begin
      frame_open = 1'b0;
    end else begin
      frame_bytes[held] = b;
      held++;
      parity ^= b;
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b);
    payload_beat_t beat;
    if (!frame_open) begin
      if (esc_armed) begin
        esc_armed = 1'b0;
      end else if (b == SymStart) begin
        frame_open = 1'b1;
        held = 0;
        parity = 8'h00;
      end else if (b == SymEsc) begin
        esc_armed = 1'b1;
      end
    end else if (esc_armed) begin
      esc_armed = 1'b0;
      if (b inside {SymStart, SymEnd, SymEsc}) store_byte(b);
      else frame_open = 1'b0;
    end else if (b == SymStart) begin
      held = 0;
      parity = 8'h00;
    end else if (b == SymEnd) begin
      frame_open = 1'b0;
      if (held == 1 && parity == 8'h00) begin
        beat = '{pbyte: 8'h00, last: 1'b1, plen: '0, empty: 1'b1};
        payload_due.push_back(beat);
      end else if (held > 1 && parity == 8'h00) begin
        for (int k = 0; k < held - 1; k++) begin
          beat = '{pbyte: frame_bytes[k], last: (k == held - 2),
                   plen: LenW'(held - 1), empty: 1'b0};
          payload_due.push_back(beat);
        end
      end
    end else if (b == SymEsc) begin
      esc_armed = 1'b1;
    end else begin
      store_byte(b);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_rx_byte(in_rx_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_in > 0) begin
          gap_in--;
          in_valid <= 1'b0;
        end else if (rx_stream.size() > 0) begin
          in_rx_byte <= rx_stream.pop_front();
          in_valid <= 1'b1;
          gap_in = pick_gap(quiet_in);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output backpressure
  always @(posedge clk) begin
    payload_beat_t got;
    payload_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{pbyte: out_payload_byte, last: out_last, plen: out_payload_len,
                empty: out_empty_frame};
        if (payload_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: byte %02h last %0d len %0d empty %0d",
                     got.pbyte, got.last, got.plen, got.empty);
        end else begin
          want = payload_due.pop_front();
          beats_checked++;
          if (want.last) frames_done++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                       want.pbyte, want.last, want.plen, want.empty,
                       got.pbyte, got.last, got.plen, got.empty);
          end
        end
      end
      if (hold_out > 0) begin
        hold_out--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_out = pick_gap(quiet_out);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [7:0] body[$];
    int r;
    int n;
    int len;
    flaw_t flaw;

    // hunting: escaped start is skipped, stray byte ignored
    rx_stream.push_back(SymEsc);
    rx_stream.push_back(SymStart);
    rx_stream.push_back(8'h55);
    // checksum only
    body = {};
    queue_frame(body, FLAW_NONE);
    // empty frame
    rx_stream.push_back(SymStart);
    rx_stream.push_back(SymEnd);
    // restart inside a frame, then escaped specials and byte extremes
    rx_stream.push_back(SymStart);
    rx_stream.push_back(8'h11);
    body = {SymStart, SymEnd, SymEsc, 8'h00, 8'hFF};
    queue_frame(body, FLAW_NONE);
    // bad escape
    rx_stream.push_back(SymStart);
    rx_stream.push_back(SymEsc);
    rx_stream.push_back(8'h41);
    // bad checksum
    body = {8'h01};
    queue_frame(body, FLAW_CHECKSUM);

    n = RxItems;
    while (rx_stream.size() < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(4, 1)) rx_stream.push_back(8'($urandom_range(255)));
        continue;
      end
      if (r < 14) begin
        rx_stream.push_back(SymStart);
        repeat ($urandom_range(3, 1)) rx_stream.push_back(plain_byte());
      end
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(6);
      else if (r < 90) len = $urandom_range(19, 7);
      else len = $urandom_range(22, 20);
      body = {};
      repeat (len) body.push_back(data_byte());
      r = $urandom_range(99);
      flaw = (r < 80) ? FLAW_NONE : (r < 90) ? FLAW_CHECKSUM : FLAW_ESCAPE;
      queue_frame(body, flaw);
    end
    rx_total = rx_stream.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < rx_total || payload_due.size() > 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);

    $display("sent %0d raw bytes with escapes, restarts, overflows and corrupted frames",
             rx_total);
    $display("checked %0d payload beats across %0d delivered frames",
             beats_checked, frames_done);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: escaped_frame_decoder_top.f
rtl/core/efd_pkg.sv
rtl/core/efd_store.sv
rtl/core/efd_ctrl.sv
rtl/core/escaped_frame_decoder_top.sv
tb/testbench.sv
